/* hdl/lif_pkg.sv */
`timescale 1ns / 1ps

package lif_pkg;

    // Field widths.
    localparam int CH_W    = 6;
    localparam int Q_W     = 24;
    localparam int COEF_W  = 17;
    localparam int TIME_W  = 32;
    localparam int CFG_IDX_W = 3;

    // A coefficient is widened by one zero bit so it multiplies as a signed value.
    localparam int PROD_W  = Q_W + COEF_W + 1;
    localparam int FRAC_W  = 16;
    localparam int TRUNC_W = PROD_W - FRAC_W;
    localparam int SUM_W   = TRUNC_W + 1;

    // Number of channels the channel field can address.
    localparam int CH_SPAN = 2 ** CH_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_FACTOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LEVEL    = 3'd4;

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic [COEF_W-1:0]     coef_t;

    typedef struct packed {
        coef_t leak_factor;
        coef_t input_gain;
        q_t    fire_threshold;
        q_t    spike_level;
        q_t    reset_level;
    } lif_cfg_t;

    localparam lif_cfg_t CFG_RESET = '{
        leak_factor:    17'd65387,
        input_gain:     17'd149,
        fire_threshold: 24'sd5120,
        spike_level:    24'sd8960,
        reset_level:    -24'sd7680
    };

    localparam q_t Q_MAX = 24'sh7FFFFF;
    localparam q_t Q_MIN = 24'sh800000;

endpackage

/* hdl/lif_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module lif_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/lif_neuron_bank.sv */
`timescale 1ns / 1ps

// Bank of leaky integrate-and-fire neurons, one membrane potential per channel.
// Each input transfer carries one synaptic current sample for one channel; the
// samples come time-major with the channels interleaved, and tlast marks the
// last channel of a time step, which advances the time index after that
// sample. For every input transfer the block emits exactly one output transfer
// with the channel, the time index, the new Q15.8 potential and the spike flag.
// The potentials live in a synchronous RAM and are updated by a
// read-modify-write pipeline: the RAM read is issued when a sample is
// accepted, the next stage resolves the stored value and does the two
// multiplications, and the last stage adds, saturates, compares against the
// threshold, writes the potential back and loads the output register. A
// result passes through the stage 1, stage 2 and output registers. The
// block accepts one sample per cycle while the output is not stalled and
// two consecutive samples name different channels; when a sample names the
// same channel as the sample directly before it, it is held back until the
// previous update of that channel reaches the write-back stage, from which it is
// forwarded. Channels at or above NUM_CHANNELS produce a normal result from a
// zero potential and are never stored. After reset all potentials read as
// zero through per-entry valid bits, so no clearing pass is needed. The
// configuration registers are written through the cfg port (always ready) and
// may only change while no samples are in flight.
module lif_neuron_bank
    import lif_pkg::*;
#(
    parameter int NUM_CHANNELS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,

    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: [5:0] channel, [29:6] current_sample, [31:30] zero.
    input  logic [31:0]          s_tdata,
    // s_tlast: last_channel.
    input  logic                 s_tlast,

    // Output stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: [5:0] out_channel, [37:6] time_index, [61:38] potential,
    // [63:62] zero.
    output logic [63:0]          m_tdata,
    // m_tuser: [0] spike.
    output logic [0:0]           m_tuser,

    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data
);

    // Only channels that the channel field can reach need storage.
    localparam int MEM_DEPTH = (NUM_CHANNELS < CH_SPAN) ? NUM_CHANNELS : CH_SPAN;
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Configuration registers.
    lif_cfg_t cfg_reg;

    // Time step counter.
    logic [TIME_W-1:0] time_reg;

    // One valid bit per stored potential; a clear bit reads as zero.
    logic [MEM_DEPTH-1:0] vld_reg;

    // Input fields.
    logic [CH_W-1:0] in_ch;
    q_t              in_cur;
    logic            in_range;
    logic [AW-1:0]   in_addr;

    // Pipeline control.
    logic pipe_en;
    logic hazard;
    logic accept;

    // Stage 1: RAM data arrives.
    logic              s1_valid_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    logic              s1_range_reg;
    q_t                s1_cur_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic              s1_stored_reg;
    logic              s1_byp_hit_reg;
    q_t                s1_byp_val_reg;
    q_t                ram_rdata;
    q_t                s1_old;
    logic signed [PROD_W-1:0] s1_mul_a;
    logic signed [PROD_W-1:0] s1_mul_b;

    // Stage 2: truncated products.
    logic              s2_valid_reg;
    logic [CH_W-1:0]   s2_ch_reg;
    logic              s2_range_reg;
    logic [TIME_W-1:0] s2_time_reg;
    logic              s2_is_spk_reg;
    logic signed [TRUNC_W-1:0] s2_prod_a_reg;
    logic signed [TRUNC_W-1:0] s2_prod_b_reg;
    logic signed [SUM_W-1:0]   s2_sum;
    q_t                s2_sat;
    logic              s2_fired;
    q_t                s2_new;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;

    // Output register.
    logic              out_valid_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [TIME_W-1:0] out_time_reg;
    q_t                out_pot_reg;
    logic              out_spike_reg;

    assign in_ch    = s_tdata[CH_W-1:0];
    assign in_cur   = s_tdata[CH_W +: Q_W];
    assign in_range = 32'(in_ch) < NUM_CHANNELS;
    assign in_addr  = in_ch[AW-1:0];

    // The whole pipeline moves whenever the output register can take a result.
    assign pipe_en  = !out_valid_reg || m_tready;

    // The item in stage 1 has no result yet, so the same channel must wait until it moves on.
    assign hazard   = s1_valid_reg && (s1_ch_reg == in_ch);
    assign s_tready = pipe_en && !hazard;
    assign accept   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEAK_FACTOR:    cfg_reg.leak_factor    <= cfg_data[COEF_W-1:0];
                REG_INPUT_GAIN:     cfg_reg.input_gain     <= cfg_data[COEF_W-1:0];
                REG_FIRE_THRESHOLD: cfg_reg.fire_threshold <= cfg_data;
                REG_SPIKE_LEVEL:    cfg_reg.spike_level    <= cfg_data;
                REG_RESET_LEVEL:    cfg_reg.reset_level    <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= TIME_W'(1);
        end
        else if (accept && s_tlast)
        begin
            time_reg <= time_reg + TIME_W'(1);
        end
    end

    // Potential memory: read at accept, written from the last stage.
    lif_ram #(
        .WIDTH (Q_W),
        .DEPTH (MEM_DEPTH)
    ) u_pot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s2_new),
        .re    (pipe_en),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Stage 1 registers. A write to the same channel in this cycle is captured
    // here, since the RAM returns the value from before the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ch_reg    <= '0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= accept;
            s1_ch_reg    <= in_ch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_range_reg   <= in_range;
            s1_cur_reg     <= in_cur;
            s1_time_reg    <= time_reg;
            s1_stored_reg  <= vld_reg[in_addr];
            s1_byp_hit_reg <= wr_en && (s2_ch_reg == in_ch);
            s1_byp_val_reg <= s2_new;
        end
    end

    always_comb
    begin
        if (!s1_range_reg)
        begin
            s1_old = '0;
        end
        else if (s1_byp_hit_reg)
        begin
            s1_old = s1_byp_val_reg;
        end
        else if (s1_stored_reg)
        begin
            s1_old = ram_rdata;
        end
        else
        begin
            s1_old = '0;
        end
    end

    assign s1_mul_a = s1_old * $signed({1'b0, cfg_reg.leak_factor});
    assign s1_mul_b = s1_cur_reg * $signed({1'b0, cfg_reg.input_gain});

    // Stage 2 registers: products with their fraction bits dropped (floor).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_ch_reg    <= '0;
            s2_range_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_range_reg <= s1_range_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s2_time_reg   <= s1_time_reg;
            s2_is_spk_reg <= (s1_old == cfg_reg.spike_level);
            s2_prod_a_reg <= s1_mul_a[PROD_W-1:FRAC_W];
            s2_prod_b_reg <= s1_mul_b[PROD_W-1:FRAC_W];
        end
    end

    assign s2_sum = {s2_prod_a_reg[TRUNC_W-1], s2_prod_a_reg}
                  + {s2_prod_b_reg[TRUNC_W-1], s2_prod_b_reg};

    always_comb
    begin
        if (s2_sum[SUM_W-1:Q_W-1] == '0 || s2_sum[SUM_W-1:Q_W-1] == '1)
        begin
            s2_sat = s2_sum[Q_W-1:0];
        end
        else if (s2_sum[SUM_W-1])
        begin
            s2_sat = Q_MIN;
        end
        else
        begin
            s2_sat = Q_MAX;
        end
    end

    // A neuron sitting at the spike level is reset and never fires on that step.
    assign s2_fired = !s2_is_spk_reg && (s2_sat > cfg_reg.fire_threshold);

    always_comb
    begin
        if (s2_is_spk_reg)
        begin
            s2_new = cfg_reg.reset_level;
        end
        else if (s2_fired)
        begin
            s2_new = cfg_reg.spike_level;
        end
        else
        begin
            s2_new = s2_sat;
        end
    end

    assign wr_en   = pipe_en && s2_valid_reg && s2_range_reg;
    assign wr_addr = s2_ch_reg[AW-1:0];

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_ch_reg    <= s2_ch_reg;
            out_time_reg  <= s2_time_reg;
            out_pot_reg   <= s2_new;
            out_spike_reg <= s2_fired;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pot_reg, out_time_reg, out_ch_reg};
    assign m_tuser  = out_spike_reg;

endmodule
